// ===== rtl/cfsl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsl_pkg: shared types and constants
// Field widths, configuration register indexes and sequencer states of the
// speed-limited camera follower.
// ----------------------------------------------------------------------------
package cfsl_pkg;

    localparam int OFS_BITS      = 15;
    localparam int SPEED_BITS    = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_OFFSET_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SPEED   = 3'd4;

    localparam logic [OFS_BITS-1:0]   VIEW_SIZE_RESET  = 15'd1;
    localparam logic [SPEED_BITS-1:0] STEP_SPEED_RESET = 10'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULT,
        ST_DECIDE,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } cfsl_state_t;

endpackage

// ===== rtl/cfsl_target_if.sv =====
// ----------------------------------------------------------------------------
// cfsl_target_if: tracked point channel
// Valid/ready channel that carries one tracked point per transfer.
// ----------------------------------------------------------------------------
interface cfsl_target_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

// ===== rtl/cfsl_view_if.sv =====
// ----------------------------------------------------------------------------
// cfsl_view_if: view offset channel
// Valid/ready channel that carries the new view offset and its status flags.
// ----------------------------------------------------------------------------
interface cfsl_view_if;
    import cfsl_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFS_BITS-1:0] view_x;
    logic [OFS_BITS-1:0] view_y;
    logic                moved;
    logic                limited;

    modport source (output valid, output view_x, output view_y, output moved,
                    output limited, input ready);
    modport sink   (input valid, input view_x, input view_y, input moved,
                    input limited, output ready);
endinterface

// ===== rtl/cfsl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cfsl_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface cfsl_cfg_if;
    import cfsl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/camera_follow_speed_limited.sv =====
// ----------------------------------------------------------------------------
// camera_follow_speed_limited: view offset that follows a point at bounded speed
// Clamps the target offset, then jumps to it or steps toward it by at most
// step_speed, using bit-serial multiply, square root and divide.
// ----------------------------------------------------------------------------
// A point is taken only while the sequencer is idle; a finished result waits in
// the output register, so the next point can be taken before it is collected.
// A frame in which the offset reaches the target (or stays put) goes from
// transfer to result through the clamp, shift-and-add squaring and the
// decision. A speed-limited frame adds the restoring square root, one root
// bit per cycle, and two parallel restoring dividers, one quotient bit per
// cycle.
// Configuration writes are accepted in every cycle.
module camera_follow_speed_limited #(
    parameter int COORD_BITS     = 16,
    parameter int ROOT_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    cfsl_target_if.sink   target,
    cfsl_view_if.source   view,
    cfsl_cfg_if.sink      cfg
);
    import cfsl_pkg::*;

    localparam int OW    = OFS_BITS;
    localparam int TW    = ((COORD_BITS > OW) ? COORD_BITS : OW) + 2;
    localparam int MW    = 2 * OW;
    localparam int D2W   = 2 * OW + 1;
    localparam int PW    = OW + SPEED_BITS;
    localparam int SW    = 2 * SPEED_BITS;
    localparam int RW    = (D2W + 1) / 2 + ROOT_FRAC_BITS;
    localparam int RADW  = 2 * RW;
    localparam int REMW  = RW + 2;
    localparam int NW    = PW + ROOT_FRAC_BITS;
    localparam int CNT_W = $clog2(NW);

    // Configuration and state
    logic [OW-1:0]         view_width_reg;
    logic [OW-1:0]         view_height_reg;
    logic [OW-1:0]         max_offset_x_reg;
    logic [OW-1:0]         max_offset_y_reg;
    logic [SPEED_BITS-1:0] step_speed_reg;
    logic [OW-1:0]         offset_x_reg;
    logic [OW-1:0]         offset_y_reg;

    cfsl_state_t state_reg;
    cfsl_state_t state_next;
    logic        out_valid_reg;
    logic        out_load;

    // Working registers
    logic [OW-1:0]         tx_reg, ty_reg;
    logic                  negx_reg, negy_reg;
    logic                  same_reg;
    logic [MW-1:0]         mcx_reg, mcy_reg;
    logic [OW-1:0]         mplrx_reg, mplry_reg;
    logic [SPEED_BITS-1:0] mplrs_reg;
    logic [SW-1:0]         mcs_reg;
    logic [D2W-1:0]        accd_reg;
    logic [PW-1:0]         accpx_reg, accpy_reg;
    logic [SW-1:0]         accs2_reg;
    logic [RADW-1:0]       rad_reg;
    logic [REMW-1:0]       sq_rem_reg;
    logic [RW-1:0]         root_reg;
    logic [NW-1:0]         numx_reg, numy_reg;
    logic [RW-1:0]         remx_reg, remy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [OW-1:0]         nx_reg, ny_reg;
    logic                  lim_reg;

    logic [OW-1:0] out_x_reg, out_y_reg;
    logic          out_moved_reg, out_limited_reg;

    // Combinational step values
    logic [OW-1:0]   tx_in, ty_in;
    logic [OW:0]     dx, dy;
    logic [OW-1:0]   magx, magy;
    logic [REMW+1:0] sq_pre, sq_trial, sq_diff;
    logic            sq_take;
    logic [RW-1:0]   root_step;
    logic [RW:0]     dvx_pre, dvy_pre, dv_div;
    logic            dvx_take, dvy_take;
    logic [OW-1:0]   qx, qy;
    logic            cnt_zero;

    function automatic logic [OW-1:0] clamp_target(
        input logic signed [COORD_BITS-1:0] p,
        input logic [OW-1:0]                size,
        input logic [OW-1:0]                maxo
    );
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] m;
        logic [OW-1:0]        r;
        t = $signed(TW'(p)) - $signed(TW'(size >> 1));
        m = $signed(TW'(maxo));
        if (t >= m)
        begin
            r = maxo;
        end
        else if (t[TW-1])
        begin
            r = '0;
        end
        else
        begin
            r = t[OW-1:0];
        end
        return r;
    endfunction

    assign tx_in = clamp_target(target.target_x, view_width_reg, max_offset_x_reg);
    assign ty_in = clamp_target(target.target_y, view_height_reg, max_offset_y_reg);

    assign target.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign view.valid   = out_valid_reg;
    assign view.view_x  = out_x_reg;
    assign view.view_y  = out_y_reg;
    assign view.moved   = out_moved_reg;
    assign view.limited = out_limited_reg;

    assign cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        dx   = {1'b0, tx_reg} - {1'b0, offset_x_reg};
        dy   = {1'b0, ty_reg} - {1'b0, offset_y_reg};
        magx = dx[OW] ? OW'(-dx) : dx[OW-1:0];
        magy = dy[OW] ? OW'(-dy) : dy[OW-1:0];

        // One root bit per cycle: bring down two radicand bits, try 4*root+1.
        sq_pre    = {sq_rem_reg, rad_reg[RADW-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_take   = (sq_pre >= sq_trial);
        sq_diff   = sq_pre - sq_trial;
        root_step = {root_reg[RW-2:0], sq_take};

        // One quotient bit per cycle on each axis, sharing the divisor.
        dv_div   = {1'b0, root_reg};
        dvx_pre  = {remx_reg, numx_reg[NW-1]};
        dvy_pre  = {remy_reg, numy_reg[NW-1]};
        dvx_take = (dvx_pre >= dv_div);
        dvy_take = (dvy_pre >= dv_div);
        qx       = {numx_reg[OW-2:0], dvx_take};
        qy       = {numy_reg[OW-2:0], dvy_take};
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (target.valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (same_reg || (accd_reg < D2W'(accs2_reg)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || view.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control state, configuration and the current offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            view_width_reg   <= VIEW_SIZE_RESET;
            view_height_reg  <= VIEW_SIZE_RESET;
            max_offset_x_reg <= '0;
            max_offset_y_reg <= '0;
            step_speed_reg   <= STEP_SPEED_RESET;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                offset_x_reg  <= nx_reg;
                offset_y_reg  <= ny_reg;
            end
            else if (view.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_VIEW_WIDTH:   view_width_reg   <= cfg.data[OW-1:0];
                    CFG_VIEW_HEIGHT:  view_height_reg  <= cfg.data[OW-1:0];
                    CFG_MAX_OFFSET_X: max_offset_x_reg <= cfg.data[OW-1:0];
                    CFG_MAX_OFFSET_Y: max_offset_y_reg <= cfg.data[OW-1:0];
                    CFG_STEP_SPEED:   step_speed_reg   <= cfg.data[SPEED_BITS-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg       <= nx_reg;
            out_y_reg       <= ny_reg;
            out_moved_reg   <= (nx_reg != offset_x_reg) || (ny_reg != offset_y_reg);
            out_limited_reg <= lim_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                tx_reg <= tx_in;
                ty_reg <= ty_in;
            end
            ST_LOAD:
            begin
                negx_reg  <= dx[OW];
                negy_reg  <= dy[OW];
                same_reg  <= (dx == '0) && (dy == '0);
                mcx_reg   <= MW'(magx);
                mcy_reg   <= MW'(magy);
                mplrx_reg <= magx;
                mplry_reg <= magy;
                mplrs_reg <= step_speed_reg;
                mcs_reg   <= SW'(step_speed_reg);
                accd_reg  <= '0;
                accpx_reg <= '0;
                accpy_reg <= '0;
                accs2_reg <= '0;
                cnt_reg   <= CNT_W'(OW - 1);
            end
            ST_MULT:
            begin
                // Squares of both deltas, delta times speed and speed squared.
                accd_reg <= accd_reg + (mplrx_reg[0] ? D2W'(mcx_reg) : '0)
                                     + (mplry_reg[0] ? D2W'(mcy_reg) : '0);
                if (mplrs_reg[0])
                begin
                    accpx_reg <= accpx_reg + mcx_reg[PW-1:0];
                    accpy_reg <= accpy_reg + mcy_reg[PW-1:0];
                    accs2_reg <= accs2_reg + mcs_reg;
                end
                mcx_reg   <= {mcx_reg[MW-2:0], 1'b0};
                mcy_reg   <= {mcy_reg[MW-2:0], 1'b0};
                mcs_reg   <= {mcs_reg[SW-2:0], 1'b0};
                mplrx_reg <= mplrx_reg >> 1;
                mplry_reg <= mplry_reg >> 1;
                mplrs_reg <= mplrs_reg >> 1;
                cnt_reg   <= cnt_reg - 1'b1;
            end
            ST_DECIDE:
            begin
                lim_reg    <= 1'b0;
                rad_reg    <= RADW'(accd_reg) << (2 * ROOT_FRAC_BITS);
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cnt_reg    <= CNT_W'(RW - 1);
                if (same_reg)
                begin
                    nx_reg <= offset_x_reg;
                    ny_reg <= offset_y_reg;
                end
                else
                begin
                    nx_reg <= tx_reg;
                    ny_reg <= ty_reg;
                end
            end
            ST_ROOT:
            begin
                rad_reg    <= {rad_reg[RADW-3:0], 2'b00};
                sq_rem_reg <= sq_take ? sq_diff[REMW-1:0] : sq_pre[REMW-1:0];
                if (cnt_zero)
                begin
                    // A zero root would divide by zero; it is forced to one.
                    root_reg <= (root_step == '0) ? RW'(1) : root_step;
                    numx_reg <= NW'(accpx_reg) << ROOT_FRAC_BITS;
                    numy_reg <= NW'(accpy_reg) << ROOT_FRAC_BITS;
                    remx_reg <= '0;
                    remy_reg <= '0;
                    cnt_reg  <= CNT_W'(NW - 1);
                end
                else
                begin
                    root_reg <= root_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                remx_reg <= dvx_take ? RW'(dvx_pre - dv_div) : dvx_pre[RW-1:0];
                remy_reg <= dvy_take ? RW'(dvy_pre - dv_div) : dvy_pre[RW-1:0];
                numx_reg <= {numx_reg[NW-2:0], dvx_take};
                numy_reg <= {numy_reg[NW-2:0], dvy_take};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    lim_reg <= 1'b1;
                    nx_reg  <= negx_reg ? (offset_x_reg - qx) : (offset_x_reg + qx);
                    ny_reg  <= negy_reg ? (offset_y_reg - qy) : (offset_y_reg + qy);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule
